/* rtl/core/ecpi_pkg.sv */
// ----------------------------------------------------------------------------
// ecpi_pkg
// Shared types and constants of the exact color palette indexer.
// ----------------------------------------------------------------------------
package ecpi_pkg;

    localparam int PALETTE_MAX_DEF = 256;
    localparam int TABLE_SLOTS_DEF = 2048;

    localparam int COMP_W  = 8;
    localparam int KEY_W   = 24;
    localparam int IDX_W   = 8;
    localparam int CNT_W   = 9;
    localparam int EPOCH_W = 8;

    localparam logic [31:0] HASH_MUL = 32'h9e37_79b1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WIPE,
        S_HASH,
        S_READ,
        S_CHECK
    } t_state;

    typedef struct packed {
        logic load;
        logic epoch_inc;
        logic epoch_rst;
        logic wipe_en;
        logic hash;
        logic rd_first;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic epoch_max;
        logic wipe_last;
        logic probe_more;
        logic out_free;
    } t_stat;

endpackage

/* rtl/core/ecpi_pix_if.sv */
// ----------------------------------------------------------------------------
// ecpi_pix_if
// Pixel channel: one RGB888 pixel and a frame start marker per beat.
// ----------------------------------------------------------------------------
interface ecpi_pix_if;
    import ecpi_pkg::*;

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              frame_start;

    modport source (output valid, red, green, blue, frame_start, input ready);
    modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

/* rtl/core/ecpi_res_if.sv */
// ----------------------------------------------------------------------------
// ecpi_res_if
// Result channel: palette index and frame status per beat.
// ----------------------------------------------------------------------------
interface ecpi_res_if;
    import ecpi_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] color_index;
    logic             new_color;
    logic             overflow;
    logic [CNT_W-1:0] color_count;

    modport source (output valid, color_index, new_color, overflow, color_count,
                    input ready);
    modport sink   (input valid, color_index, new_color, overflow, color_count,
                    output ready);
endinterface

/* rtl/core/ecpi_cfg_if.sv */
// ----------------------------------------------------------------------------
// ecpi_cfg_if
// Configuration channel: color budget write data.
// ----------------------------------------------------------------------------
interface ecpi_cfg_if;
    import ecpi_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/core/ecpi_ram.sv */
// ----------------------------------------------------------------------------
// ecpi_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ecpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* rtl/core/ecpi_dp.sv */
// ----------------------------------------------------------------------------
// ecpi_dp
// Datapath: key hash, slot table probe, palette count, budget and result.
// ----------------------------------------------------------------------------
module ecpi_dp #(
    parameter int PALETTE_MAX = ecpi_pkg::PALETTE_MAX_DEF,
    parameter int TABLE_SLOTS = ecpi_pkg::TABLE_SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ecpi_pkg::t_cmd               i_cmd,
    output ecpi_pkg::t_stat              o_stat,
    input  logic [ecpi_pkg::COMP_W-1:0]  i_red,
    input  logic [ecpi_pkg::COMP_W-1:0]  i_green,
    input  logic [ecpi_pkg::COMP_W-1:0]  i_blue,
    input  logic                         i_frame_start,
    input  logic                         i_cfg_we,
    input  logic [ecpi_pkg::CNT_W-1:0]   i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [ecpi_pkg::IDX_W-1:0]   o_color_index,
    output logic                         o_new_color,
    output logic                         o_overflow,
    output logic [ecpi_pkg::CNT_W-1:0]   o_color_count
);
    import ecpi_pkg::*;

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W = EPOCH_W + KEY_W + IDX_W;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   idx;
    } t_entry;

    logic [KEY_W-1:0]   r_key,   n_key;
    logic [31:0]        r_prod,  n_prod;
    logic [SLOT_W-1:0]  r_pos,   n_pos;
    logic [SLOT_W-1:0]  r_wipe,  n_wipe;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_ovf,   n_ovf;
    logic [CNT_W-1:0]   r_budget, n_budget;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx,   n_out_idx;
    logic               r_out_new,   n_out_new;
    logic               r_out_ovf,   n_out_ovf;
    logic [CNT_W-1:0]   r_out_cnt,   n_out_cnt;

    logic [31:0]       w_mix;
    logic [31:0]       w_hash;
    logic [CNT_W-1:0]  w_limit;
    t_entry            w_q;
    t_entry            w_wr_data;
    logic [ENTRY_W-1:0] w_rd_raw;
    logic              w_live;
    logic              w_match;
    logic              w_wr_en;
    logic [SLOT_W-1:0] w_wr_addr;
    logic              w_rd_en;
    logic [SLOT_W-1:0] w_rd_addr;
    logic              w_out_free;

    assign w_mix  = {8'd0, r_key} ^ ({8'd0, r_key} >> 13);
    assign w_hash = r_prod ^ (r_prod >> 16);

    assign w_limit = (r_budget == '0 || r_budget > CNT_W'(PALETTE_MAX))
                   ? CNT_W'(PALETTE_MAX) : r_budget;

    assign w_q     = t_entry'(w_rd_raw);
    assign w_live  = (w_q.epoch == r_epoch);
    assign w_match = w_live && (w_q.key == r_key);

    assign w_out_free = !r_out_valid || i_ready;

    assign o_stat.epoch_max  = (r_epoch == '1);
    assign o_stat.wipe_last  = (r_wipe == SLOT_W'(TABLE_SLOTS - 1));
    assign o_stat.probe_more = !r_ovf && w_live && !w_match;
    assign o_stat.out_free   = w_out_free;

    assign w_rd_en   = i_cmd.rd_first || i_cmd.step;
    assign w_rd_addr = i_cmd.rd_first ? w_hash[SLOT_W-1:0] : r_pos + 1'b1;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = '{epoch: r_epoch, key: r_key, idx: r_count[IDX_W-1:0]};
        if (i_cmd.wipe_en) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_wipe;
            w_wr_data = '0;
        end else if (i_cmd.finish && !r_ovf && !w_match && r_count < w_limit) begin
            w_wr_en = 1'b1;
        end
    end

    always_comb begin
        n_key       = r_key;
        n_prod      = r_prod;
        n_pos       = r_pos;
        n_wipe      = r_wipe;
        n_epoch     = r_epoch;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_budget    = r_budget;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_new   = r_out_new;
        n_out_ovf   = r_out_ovf;
        n_out_cnt   = r_out_cnt;

        if (i_cfg_we) begin
            n_budget = i_cfg_data;
        end
        if (i_cmd.load) begin
            n_key = {i_red, i_green, i_blue};
            if (i_frame_start) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
        if (i_cmd.epoch_inc) begin
            n_epoch = r_epoch + 1'b1;
        end
        if (i_cmd.epoch_rst) begin
            n_epoch = EPOCH_W'(1);
        end
        if (i_cmd.wipe_en) begin
            n_wipe = r_wipe + 1'b1;
        end
        if (i_cmd.hash) begin
            n_prod = w_mix * HASH_MUL;
        end
        if (i_cmd.rd_first || i_cmd.step) begin
            n_pos = w_rd_addr;
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_out_idx   = '0;
            n_out_new   = 1'b0;
            n_out_ovf   = r_ovf;
            n_out_cnt   = r_count;
            if (!r_ovf) begin
                if (w_match) begin
                    n_out_idx = w_q.idx;
                end else if (r_count >= w_limit) begin
                    n_ovf     = 1'b1;
                    n_out_ovf = 1'b1;
                end else begin
                    n_count   = r_count + 1'b1;
                    n_out_idx = r_count[IDX_W-1:0];
                    n_out_new = 1'b1;
                    n_out_cnt = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wipe      <= '0;
            r_epoch     <= EPOCH_W'(1);
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_budget    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wipe      <= n_wipe;
            r_epoch     <= n_epoch;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_budget    <= n_budget;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_prod    <= n_prod;
        r_pos     <= n_pos;
        r_out_idx <= n_out_idx;
        r_out_new <= n_out_new;
        r_out_ovf <= n_out_ovf;
        r_out_cnt <= n_out_cnt;
    end

    ecpi_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_raw)
    );

    assign o_valid       = r_out_valid;
    assign o_color_index = r_out_idx;
    assign o_new_color   = r_out_new;
    assign o_overflow    = r_out_ovf;
    assign o_color_count = r_out_cnt;
endmodule

/* rtl/core/ecpi_ctrl.sv */
// ----------------------------------------------------------------------------
// ecpi_ctrl
// Controller: table wipe, pixel accept, hash, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module ecpi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_frame_start,
    output logic            o_in_ready,
    input  ecpi_pkg::t_stat i_stat,
    output ecpi_pkg::t_cmd  o_cmd
);
    import ecpi_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.wipe_en = 1'b1;
                if (i_stat.wipe_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                    if (i_frame_start) begin
                        if (i_stat.epoch_max) begin
                            o_cmd.epoch_rst = 1'b1;
                            n_state         = S_WIPE;
                        end else begin
                            o_cmd.epoch_inc = 1'b1;
                        end
                    end
                end
            end
            S_WIPE: begin
                o_cmd.wipe_en = 1'b1;
                if (i_stat.wipe_last) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rd_first = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.probe_more) begin
                    o_cmd.step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end
endmodule

/* rtl/core/exact_color_palette_indexer.sv */
// ----------------------------------------------------------------------------
// exact_color_palette_indexer
// Assigns each exact RGB888 color of a frame a palette index in order of
// first appearance, through an open-addressed hash table with linear probing.
//
//   channel   modport   beat carries
//   i_pix     sink      red, green, blue, frame_start
//   o_res     source    color_index, new_color, overflow, color_count
//   i_cfg     sink      color_budget (9 bits)
//
// a pixel passes accept, hash multiply, first slot read, compare and commit,
// and each extra probe of the slot table repeats the slot read and compare
// after reset the slot table is wiped before i_pix is ready; every
// 255th frame_start repeats that wipe before the pixel
// the result register lets the next pixel enter while a result waits;
// a second result stalls the pixel in its compare step
// TABLE_SLOTS must be a power of two
// ----------------------------------------------------------------------------
module exact_color_palette_indexer #(
    parameter int PALETTE_MAX = ecpi_pkg::PALETTE_MAX_DEF,
    parameter int TABLE_SLOTS = ecpi_pkg::TABLE_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecpi_pix_if.sink   i_pix,
    ecpi_res_if.source o_res,
    ecpi_cfg_if.sink   i_cfg
);
    import ecpi_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_pix.ready = w_in_ready;
    assign i_cfg.ready = 1'b1;

    ecpi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_pix.valid),
        .i_frame_start (i_pix.frame_start),
        .o_in_ready    (w_in_ready),
        .i_stat        (w_stat),
        .o_cmd         (w_cmd)
    );

    ecpi_dp #(
        .PALETTE_MAX (PALETTE_MAX),
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_red         (i_pix.red),
        .i_green       (i_pix.green),
        .i_blue        (i_pix.blue),
        .i_frame_start (i_pix.frame_start),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_color_index (o_res.color_index),
        .o_new_color   (o_res.new_color),
        .o_overflow    (o_res.overflow),
        .o_color_count (o_res.color_count)
    );
endmodule
